>>> hdl/gha_pkg.sv
package gha_pkg;

   localparam int KEY_W = 10;
   localparam int GEN_W = 16;
   localparam int PAY_W = 32;
   localparam int CNT_W = 11;

   typedef enum logic [1:0] {
      ACT_ALLOC  = 2'd0,
      ACT_PUT    = 2'd1,
      ACT_GET    = 2'd2,
      ACT_REMOVE = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FILL,
      ST_HEAD,
      ST_EXEC
   } state_type;

   typedef struct packed {
      logic [GEN_W-1:0] generation;
      logic [KEY_W-1:0] link;
      logic [PAY_W-1:0] payload;
   } slot_entry_type;

endpackage

>>> hdl/gha_ram.sv
module gha_ram #(
   parameter int WIDTH  = 58,
   parameter int DEPTH  = 1024,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/generational_handle_allocator_unit.sv
// Generational handle allocator. A transaction is accepted when start is high while busy is
// low, and its result appears on the rsp_ ports for exactly one cycle with rsp_strobe high; the
// receiver cannot stall, so it must take every result in that cycle. A put, get or remove
// first reads the slot from the slot memory, then updates it and registers the result.
// A new transaction may be accepted in the same cycle that the previous result is shown.
// An allocate that finds the free list empty while the table is not full first enables the
// next row, writing its SLOTS_PER_ROW slots one per cycle through the single write port,
// then reads the new free-list head and completes. No clearing pass is needed after reset.
module generational_handle_allocator_unit #(
   parameter int SLOTS_PER_ROW = 64,
   parameter int ROW_COUNT     = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic [1:0]                req_action,
   input  logic [gha_pkg::KEY_W-1:0] req_slot_key,
   input  logic [gha_pkg::GEN_W-1:0] req_generation_in,
   input  logic [gha_pkg::PAY_W-1:0] req_payload_in,
   output logic                      rsp_strobe,
   output logic [gha_pkg::KEY_W-1:0] rsp_key_out,
   output logic [gha_pkg::GEN_W-1:0] rsp_generation_out,
   output logic [gha_pkg::PAY_W-1:0] rsp_payload_out,
   output logic                      rsp_error_flag,
   output logic [gha_pkg::KEY_W-1:0] rsp_live_total,
   output logic [gha_pkg::KEY_W-1:0] rsp_free_total
);

   localparam int TABLE_SIZE = SLOTS_PER_ROW * ROW_COUNT;
   localparam int AW         = $clog2(TABLE_SIZE);
   localparam int AW1        = $clog2(TABLE_SIZE + 1);
   localparam int FW         = $clog2(SLOTS_PER_ROW);
   localparam int CW         = (AW1 > gha_pkg::KEY_W) ? AW1 : gha_pkg::KEY_W;
   localparam int EW         = $bits(gha_pkg::slot_entry_type);

   gha_pkg::state_type  state_ff, state_in;
   logic [FW-1:0]       fill_cnt_ff, fill_cnt_in;
   logic [AW1-1:0]      limit_ff, limit_in;
   logic [gha_pkg::KEY_W-1:0] head_ff, head_in;
   logic [gha_pkg::CNT_W-1:0] free_cnt_ff, free_cnt_in;
   logic [gha_pkg::CNT_W-1:0] live_cnt_ff, live_cnt_in;

   gha_pkg::action_type       req_action_ff;
   logic [gha_pkg::KEY_W-1:0] req_key_ff;
   logic [gha_pkg::GEN_W-1:0] req_gen_ff;
   logic [gha_pkg::PAY_W-1:0] req_pay_ff;

   logic                      rsp_strobe_ff, rsp_strobe_in;
   logic [gha_pkg::KEY_W-1:0] rsp_key_ff, rsp_key_in;
   logic [gha_pkg::GEN_W-1:0] rsp_gen_ff, rsp_gen_in;
   logic [gha_pkg::PAY_W-1:0] rsp_pay_ff, rsp_pay_in;
   logic                      rsp_err_ff, rsp_err_in;

   logic                      ram_we;
   logic [AW-1:0]             ram_wr_addr;
   gha_pkg::slot_entry_type   wr_entry;
   logic                      ram_rd_en;
   logic [AW-1:0]             ram_rd_addr;
   logic [EW-1:0]             ram_rd_data;
   gha_pkg::slot_entry_type   rd_entry;

   logic                      accept;
   logic [AW1-1:0]            fill_key;
   logic                      fill_last;
   logic                      table_full;
   logic [CW-1:0]             key_cw;
   logic                      key_in_table;
   logic                      row_on;
   logic                      head_ok;

   gha_ram #(
      .WIDTH  (EW),
      .DEPTH  (TABLE_SIZE),
      .ADDR_W (AW)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wr_addr),
      .wr_data (wr_entry),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign rd_entry = gha_pkg::slot_entry_type'(ram_rd_data);

   // Rows are enabled in ascending order, so the enabled rows are exactly the keys from
   // SLOTS_PER_ROW up to the base of the next row to be enabled.
   assign accept       = start && (state_ff == gha_pkg::ST_IDLE);
   assign fill_key     = limit_ff + AW1'(fill_cnt_ff);
   assign fill_last    = (fill_cnt_ff == FW'(SLOTS_PER_ROW - 1));
   assign table_full   = (limit_ff == AW1'(TABLE_SIZE));
   assign key_cw       = CW'(req_key_ff);
   assign key_in_table = key_cw < CW'(TABLE_SIZE);
   assign row_on       = (key_cw >= CW'(SLOTS_PER_ROW)) && (key_cw < CW'(limit_ff));
   assign head_ok      = (head_ff != '0) && (CW'(head_ff) < CW'(TABLE_SIZE));

   always_comb begin
      state_in      = state_ff;
      fill_cnt_in   = fill_cnt_ff;
      limit_in      = limit_ff;
      head_in       = head_ff;
      free_cnt_in   = free_cnt_ff;
      live_cnt_in   = live_cnt_ff;
      rsp_strobe_in = 1'b0;
      rsp_key_in    = '0;
      rsp_gen_in    = '0;
      rsp_pay_in    = '0;
      rsp_err_in    = 1'b0;
      ram_rd_en     = 1'b0;
      ram_rd_addr   = AW'(head_ff);
      ram_we        = 1'b0;
      ram_wr_addr   = AW'(fill_key);
      wr_entry      = rd_entry;

      unique case (state_ff)
         gha_pkg::ST_IDLE: begin
            if (start) begin
               ram_rd_en = 1'b1;
               state_in  = gha_pkg::ST_EXEC;
               if (gha_pkg::action_type'(req_action) == gha_pkg::ACT_ALLOC) begin
                  if ((head_ff == '0) && !table_full) begin
                     state_in = gha_pkg::ST_FILL;
                  end
               end else begin
                  ram_rd_addr = AW'(req_slot_key);
               end
            end
         end
         gha_pkg::ST_FILL: begin
            ram_we              = 1'b1;
            wr_entry.generation = '0;
            wr_entry.payload    = '0;
            wr_entry.link       = fill_last ? head_ff : gha_pkg::KEY_W'(fill_key + AW1'(1));
            fill_cnt_in         = fill_cnt_ff + FW'(1);
            if (fill_last) begin
               fill_cnt_in = '0;
               limit_in    = limit_ff + AW1'(SLOTS_PER_ROW);
               head_in     = gha_pkg::KEY_W'(limit_ff);
               free_cnt_in = free_cnt_ff + gha_pkg::CNT_W'(SLOTS_PER_ROW);
               state_in    = gha_pkg::ST_HEAD;
            end
         end
         gha_pkg::ST_HEAD: begin
            ram_rd_en = 1'b1;
            state_in  = gha_pkg::ST_EXEC;
         end
         gha_pkg::ST_EXEC: begin
            state_in      = gha_pkg::ST_IDLE;
            rsp_strobe_in = 1'b1;
            ram_wr_addr   = AW'(req_key_ff);
            if (req_action_ff == gha_pkg::ACT_ALLOC) begin
               if (head_ok) begin
                  rsp_key_in  = head_ff;
                  rsp_gen_in  = rd_entry.generation;
                  free_cnt_in = free_cnt_ff - gha_pkg::CNT_W'(1);
                  head_in     = rd_entry.link;
               end
            end else if (!key_in_table) begin
               rsp_err_in = 1'b1;
            end else begin
               unique case (req_action_ff)
                  gha_pkg::ACT_PUT: begin
                     if (!row_on || (rd_entry.payload != '0)
                         || (rd_entry.generation != req_gen_ff)) begin
                        rsp_err_in = 1'b1;
                     end else if (req_pay_ff != '0) begin
                        ram_we           = 1'b1;
                        wr_entry.payload = req_pay_ff;
                        live_cnt_in      = live_cnt_ff + gha_pkg::CNT_W'(1);
                     end
                  end
                  gha_pkg::ACT_GET: begin
                     if (row_on) begin
                        rsp_gen_in = rd_entry.generation;
                        rsp_pay_in = rd_entry.payload;
                     end
                  end
                  gha_pkg::ACT_REMOVE: begin
                     if (row_on) begin
                        if (rd_entry.generation != req_gen_ff) begin
                           rsp_err_in = 1'b1;
                        end else begin
                           rsp_pay_in = rd_entry.payload;
                           if (rd_entry.payload != '0) begin
                              live_cnt_in = live_cnt_ff - gha_pkg::CNT_W'(1);
                           end
                           ram_we              = 1'b1;
                           wr_entry.payload    = '0;
                           wr_entry.generation = rd_entry.generation + gha_pkg::GEN_W'(1);
                           wr_entry.link       = head_ff;
                           head_in             = req_key_ff;
                           free_cnt_in         = free_cnt_ff + gha_pkg::CNT_W'(1);
                        end
                     end
                  end
                  gha_pkg::ACT_ALLOC: begin
                  end
               endcase
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= gha_pkg::ST_IDLE;
         fill_cnt_ff   <= '0;
         limit_ff      <= AW1'(SLOTS_PER_ROW);
         head_ff       <= '0;
         free_cnt_ff   <= '0;
         live_cnt_ff   <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         fill_cnt_ff   <= fill_cnt_in;
         limit_ff      <= limit_in;
         head_ff       <= head_in;
         free_cnt_ff   <= free_cnt_in;
         live_cnt_ff   <= live_cnt_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req_action_ff <= gha_pkg::action_type'(req_action);
         req_key_ff    <= req_slot_key;
         req_gen_ff    <= req_generation_in;
         req_pay_ff    <= req_payload_in;
      end
      if (rsp_strobe_in) begin
         rsp_key_ff <= rsp_key_in;
         rsp_gen_ff <= rsp_gen_in;
         rsp_pay_ff <= rsp_pay_in;
         rsp_err_ff <= rsp_err_in;
      end
   end

   assign busy               = (state_ff != gha_pkg::ST_IDLE);
   assign rsp_strobe         = rsp_strobe_ff;
   assign rsp_key_out        = rsp_key_ff;
   assign rsp_generation_out = rsp_gen_ff;
   assign rsp_payload_out    = rsp_pay_ff;
   assign rsp_error_flag     = rsp_err_ff;
   assign rsp_live_total     = live_cnt_ff[gha_pkg::KEY_W-1:0];
   assign rsp_free_total     = free_cnt_ff[gha_pkg::KEY_W-1:0];

   a_strobe_after_exec: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(state_ff == gha_pkg::ST_EXEC))
      else $error("Result strobe without a completed transaction.");

   a_exec_returns_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == gha_pkg::ST_EXEC) |=> (state_ff == gha_pkg::ST_IDLE))
      else $error("Transaction did not finish after its update cycle.");

   a_write_states: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> ((state_ff == gha_pkg::ST_FILL) || (state_ff == gha_pkg::ST_EXEC)))
      else $error("Slot memory written outside a fill or update cycle.");

   a_limit_bound: assert property (@(posedge clock) disable iff (reset)
      CW'(limit_ff) <= CW'(TABLE_SIZE))
      else $error("Enabled row limit ran past the table.");

   a_fill_from_empty: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == gha_pkg::ST_IDLE) && (state_in == gha_pkg::ST_FILL))
      |-> ((head_ff == '0) && !table_full))
      else $error("Row enabled while free slots remain or the table is full.");

endmodule
